### rtl/mts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants of the Markov transition sampler.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int STATES     = 64;
  localparam int COUNT_BITS = 32;

  localparam int ROW_W  = $clog2(STATES);
  localparam int CELLS  = STATES * STATES;
  localparam int CELL_W = 2 * ROW_W;
  localparam int LEN_W  = $clog2(STATES + 1);
  localparam int SUM_W  = 38;
  localparam int NZ_W   = 13;
  localparam int UNI_W  = 32;
  localparam int SAT_W  = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_CUM = 2'd1;
  localparam logic [1:0] FUNC_SMP = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [5:0]       from_state;
    logic [5:0]       to_state;
    logic [31:0]      weight;
    logic [UNI_W-1:0] uniform;
  } mts_in_t;

  typedef struct packed {
    logic [5:0]       next_state;
    logic [SUM_W-1:0] row_total;
    logic [NZ_W-1:0]  nonzero_count;
  } mts_out_t;

endpackage

### rtl/markov_transition_sampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markov_transition_sampler_top
// Sparse transition count table with inverse-CDF next-state sampling.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive a word on cmd and raise start; the word is taken
//   at the rising edge where start is high and busy is low. busy stays high
//   until the result is out.
//   Result channel: done is high for exactly one cycle with the result word
//   on result. The receiver cannot stall; sample it in that cycle. A new
//   command may be taken in the same cycle that done is high.
//   Steps from the accepting edge to done:
//     add (and the unused code)  read count, length and total, then write
//     sample                     read total and list length, form the threshold,
//                                then scan the row list as of the last cumulate
//                                until an entry matches or the list ends (one list
//                                entry read per cycle from the running-sum memory)
//     cumulate                   walk every row, then read the command row's total;
//                                each row costs a length read, each entry a list
//                                read then a count read
//   Rate: one command at a time.
//   Reset: rst (synchronous) starts a clearing pass over all CELLS (4096)
//   addresses that zeroes the count memory and the per-row length and total
//   memories; busy is high throughout.
// ----------------------------------------------------------------------------
module markov_transition_sampler_top
  import mts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  mts_in_t  cmd,
  output logic     done,
  output mts_out_t result
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE,
    S_ADD_RD, S_ADD_WR,
    S_SMP_RD, S_SMP_MUL, S_SMP_THR, S_SCAN,
    S_CUM_LEN, S_CUM_LEN_W, S_CUM_CNT, S_CUM_ACC, S_CUM_TOT, S_CUM_OUT
  } state_t;

  state_t state;

  // Memories: counts, column lists and running sums per cell; lengths and
  // totals per row.
  logic [COUNT_BITS-1:0] cnt_mem  [CELLS];
  logic [ROW_W-1:0]      list_mem [CELLS];
  logic [SUM_W-1:0]      sum_mem  [CELLS];
  logic [LEN_W-1:0]      len_mem  [STATES];
  logic [LEN_W-1:0]      clen_mem [STATES];
  logic [SUM_W-1:0]      tot_mem  [STATES];

  logic [COUNT_BITS-1:0] cnt_q;
  logic [ROW_W-1:0]      list_q;
  logic [SUM_W-1:0]      sum_q;
  logic [LEN_W-1:0]      len_q;
  logic [LEN_W-1:0]      clen_q;
  logic [SUM_W-1:0]      tot_q;

  logic [CELL_W-1:0] cnt_ra, list_ra, sum_ra;
  logic [ROW_W-1:0]  len_ra, clen_ra, tot_ra;

  logic                  cnt_we, list_we, sum_we, len_we, clen_we, tot_we;
  logic [CELL_W-1:0]     cnt_wa, list_wa, sum_wa;
  logic [ROW_W-1:0]      len_wa, clen_wa, tot_wa;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic [ROW_W-1:0]      list_wd;
  logic [SUM_W-1:0]      sum_wd;
  logic [LEN_W-1:0]      len_wd, clen_wd;
  logic [SUM_W-1:0]      tot_wd;

  // Working registers
  mts_in_t           cmd_r;
  logic [CELL_W-1:0] clr_idx;
  logic [ROW_W-1:0]  cr;        // cumulate row
  logic [LEN_W-1:0]  ck;        // cumulate list position
  logic [LEN_W-1:0]  clen_r;    // list length in hand
  logic [SUM_W-1:0]  acc;
  logic [63:0]       p_lo;
  logic [SUM_W-1:0]  p_hi;      // uniform times the top bits stays below the total
  logic [SUM_W-1:0]  thr;
  logic [SUM_W-1:0]  total_r;
  logic [LEN_W-1:0]  sk;        // scan position issued
  logic              chk;       // a scan read is in flight
  logic [NZ_W-1:0]   nz;

  logic [ROW_W-1:0]  row, col;
  logic              row_ok, add_act, is_new;
  logic [SAT_W-1:0]  sat_sum;
  logic [SUM_W-1:0]  acc_next;
  logic [LEN_W-1:0]  ck_inc;
  logic [NZ_W-1:0]   nz_next;
  logic              hit;

  assign row     = cmd_r.from_state[ROW_W-1:0];
  assign col     = cmd_r.to_state[ROW_W-1:0];
  assign row_ok  = int'(cmd_r.from_state) < STATES;
  assign add_act = (cmd_r.func == FUNC_ADD) && row_ok && (int'(cmd_r.to_state) < STATES)
                   && (cmd_r.weight != '0);
  assign is_new  = add_act && (cnt_q == '0);
  assign sat_sum = SAT_W'(cnt_q) + SAT_W'(cmd_r.weight);
  assign nz_next = is_new ? nz + NZ_W'(1) : nz;
  assign acc_next = acc + SUM_W'(cnt_q);
  assign ck_inc   = ck + LEN_W'(1);
  assign hit      = chk && (sum_q >= thr);
  assign busy     = (state != S_IDLE);

  // Memory ports: addresses and write enables follow the state
  always_comb begin
    cnt_ra  = {row, col};
    list_ra = {cr, ck[ROW_W-1:0]};
    sum_ra  = {row, sk[ROW_W-1:0]};
    len_ra  = row;
    clen_ra = row;
    tot_ra  = row;
    cnt_we  = 1'b0;
    list_we = 1'b0;
    sum_we  = 1'b0;
    len_we  = 1'b0;
    clen_we = 1'b0;
    tot_we  = 1'b0;
    cnt_wa  = {row, col};
    list_wa = {row, len_q[ROW_W-1:0]};
    sum_wa  = {cr, ck[ROW_W-1:0]};
    len_wa  = row;
    clen_wa = cr;
    tot_wa  = cr;
    cnt_wd  = (sat_sum > SAT_W'({COUNT_BITS{1'b1}})) ? '1 : sat_sum[COUNT_BITS-1:0];
    list_wd = col;
    sum_wd  = acc_next;
    len_wd  = len_q + LEN_W'(1);
    clen_wd = clen_r;
    tot_wd  = acc_next;
    case (state)
      S_CLEAR: begin
        cnt_we  = 1'b1;
        len_we  = 1'b1;
        clen_we = 1'b1;
        tot_we  = 1'b1;
        cnt_wa  = clr_idx;
        len_wa  = clr_idx[ROW_W-1:0];
        clen_wa = clr_idx[ROW_W-1:0];
        tot_wa  = clr_idx[ROW_W-1:0];
        cnt_wd  = '0;
        len_wd  = '0;
        clen_wd = '0;
        tot_wd  = '0;
      end
      S_ADD_WR: begin
        cnt_we = add_act;
        if (is_new && (int'(len_q) < STATES)) begin
          list_we = 1'b1;
          len_we  = 1'b1;
        end
      end
      S_SCAN: begin
        list_ra = {row, sk[ROW_W-1:0]};
      end
      S_CUM_LEN: begin
        len_ra = cr;
      end
      S_CUM_LEN_W: begin
        list_ra = {cr, {ROW_W{1'b0}}};
        if (len_q == '0) begin
          clen_we = 1'b1;
          clen_wd = '0;
        end
      end
      S_CUM_CNT: begin
        cnt_ra = {cr, list_q};
      end
      S_CUM_ACC: begin
        sum_we  = 1'b1;
        list_ra = {cr, ck_inc[ROW_W-1:0]};
        if (ck_inc == clen_r) begin
          clen_we = 1'b1;
          tot_we  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Memory arrays with registered reads
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_q <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (list_we) list_mem[list_wa] <= list_wd;
    list_q <= list_mem[list_ra];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    sum_q <= sum_mem[sum_ra];
  end

  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_wa] <= len_wd;
    len_q <= len_mem[len_ra];
  end

  always_ff @(posedge clk) begin
    if (clen_we) clen_mem[clen_wa] <= clen_wd;
    clen_q <= clen_mem[clen_ra];
  end

  always_ff @(posedge clk) begin
    if (tot_we) tot_mem[tot_wa] <= tot_wd;
    tot_q <= tot_mem[tot_ra];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      nz      <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + CELL_W'(1);
          if (clr_idx == CELL_W'(CELLS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            cmd_r <= cmd;
            cr    <= '0;
            case (cmd.func)
              FUNC_CUM: state <= S_CUM_LEN;
              FUNC_SMP: state <= S_SMP_RD;
              default:  state <= S_ADD_RD;
            endcase
          end
        end
        S_ADD_RD: state <= S_ADD_WR;
        S_ADD_WR: begin
          nz                   <= nz_next;
          done                 <= 1'b1;
          result.next_state    <= '0;
          result.row_total     <= row_ok ? tot_q : '0;
          result.nonzero_count <= nz_next;
          state                <= S_IDLE;
        end
        S_SMP_RD: state <= S_SMP_MUL;
        S_SMP_MUL: begin
          // split the total at bit 32 so each product stays narrow
          p_lo    <= 64'(cmd_r.uniform) * 64'(tot_q[31:0]);
          p_hi    <= SUM_W'(cmd_r.uniform) * SUM_W'(tot_q[SUM_W-1:32]);
          total_r <= row_ok ? tot_q : '0;
          clen_r  <= row_ok ? clen_q : '0;
          sk      <= '0;
          chk     <= 1'b0;
          state   <= S_SMP_THR;
        end
        S_SMP_THR: begin
          thr   <= p_hi + SUM_W'(p_lo[63:32]) + SUM_W'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (hit || (sk == clen_r)) begin
            done                 <= 1'b1;
            result.next_state    <= hit ? 6'(list_q) : '0;
            result.row_total     <= total_r;
            result.nonzero_count <= nz;
            state                <= S_IDLE;
          end else begin
            sk  <= sk + LEN_W'(1);
            chk <= 1'b1;
          end
        end
        S_CUM_LEN: state <= S_CUM_LEN_W;
        S_CUM_LEN_W: begin
          ck     <= '0;
          acc    <= '0;
          clen_r <= len_q;
          if (len_q != '0) begin
            state <= S_CUM_CNT;
          end else if (cr == ROW_W'(STATES - 1)) begin
            state <= S_CUM_TOT;
          end else begin
            cr    <= cr + ROW_W'(1);
            state <= S_CUM_LEN;
          end
        end
        S_CUM_CNT: state <= S_CUM_ACC;
        S_CUM_ACC: begin
          acc <= acc_next;
          ck  <= ck_inc;
          if (ck_inc != clen_r) begin
            state <= S_CUM_CNT;
          end else if (cr == ROW_W'(STATES - 1)) begin
            state <= S_CUM_TOT;
          end else begin
            cr    <= cr + ROW_W'(1);
            state <= S_CUM_LEN;
          end
        end
        S_CUM_TOT: state <= S_CUM_OUT;
        S_CUM_OUT: begin
          done                 <= 1'b1;
          result.next_state    <= '0;
          result.row_total     <= row_ok ? tot_q : '0;
          result.nonzero_count <= nz;
          state                <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/mts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_port_checker
// Port-level checks of the sampler's command and result behaviour.
// ----------------------------------------------------------------------------
module mts_port_checker
  import mts_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input mts_in_t  cmd,
  input logic     done,
  input mts_out_t result
);

  logic cmd_take;
  assign cmd_take = start && !busy && (cmd.func == cmd.func);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word shown while busy");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> busy)
    else $error("busy not raised after a command word");

  a_take_no_done: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> !done)
    else $error("result word in the cycle after a command word");

  a_nz_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (int'(result.nonzero_count) <= CELLS))
    else $error("nonzero count above the table size");

endmodule

bind markov_transition_sampler_top mts_port_checker u_mts_checker (.*);

### verif/mts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_checker
// Watches the command and result channels of the transition sampler, keeps
// its own copy of the count table, column lists and cumulated sums, predicts
// each result word and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module mts_checker
  import mts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  mts_in_t  cmd,
  input  logic     done,
  input  mts_out_t result,
  output int       fail_count,
  output int       pending,
  output int       result_count
);

  logic [COUNT_BITS-1:0] tally    [STATES][STATES];
  logic [ROW_W-1:0]      col_list [STATES][STATES];
  logic [LEN_W-1:0]      list_len [STATES];
  logic [SUM_W-1:0]      run_sum  [STATES][STATES];
  logic [LEN_W-1:0]      cum_len  [STATES];
  logic [SUM_W-1:0]      row_sum  [STATES];
  logic [NZ_W-1:0]       distinct;

  mts_out_t expected_q [$];
  mts_in_t  cmd_q      [$];
  mts_out_t want;
  mts_in_t  cmd_seen;
  int       n_fail = 0;
  int       n_res  = 0;

  // Apply one command word to the local state and work out its result word.
  task automatic predict_word(input mts_in_t c, output mts_out_t r);
    logic [COUNT_BITS-1:0]  cur;
    logic [COUNT_BITS:0]    wide;
    logic [SUM_W-1:0]       acc;
    logic [SUM_W+UNI_W-1:0] prod;
    logic [SUM_W:0]         thr;
    logic                   hit;
    int                     row;
    int                     k;
    r = '0;
    case (c.func)
      FUNC_ADD: begin
        if (c.weight != '0) begin
          cur = tally[c.from_state][c.to_state];
          if (cur == '0) begin
            if (list_len[c.from_state] < STATES) begin
              col_list[c.from_state][list_len[c.from_state]] = c.to_state;
              list_len[c.from_state] = list_len[c.from_state] + 1'b1;
            end
            distinct = distinct + 1'b1;
          end
          wide = cur + c.weight;
          tally[c.from_state][c.to_state] = wide[COUNT_BITS] ? '1 : wide[COUNT_BITS-1:0];
        end
      end
      FUNC_CUM: begin
        for (row = 0; row < STATES; row++) begin
          acc = '0;
          for (k = 0; k < list_len[row]; k++) begin
            acc = acc + tally[row][col_list[row][k]];
            run_sum[row][k] = acc;
          end
          cum_len[row] = list_len[row];
          if (list_len[row] != '0) row_sum[row] = acc;
        end
      end
      FUNC_SMP: begin
        // threshold is floor(uniform * total / 2^32) + 1
        prod = c.uniform * row_sum[c.from_state];
        thr  = prod[SUM_W+UNI_W-1:UNI_W] + 1'b1;
        hit  = 1'b0;
        for (k = 0; k < cum_len[c.from_state]; k++) begin
          if (!hit && run_sum[c.from_state][k] >= thr) begin
            hit          = 1'b1;
            r.next_state = col_list[c.from_state][k];
          end
        end
      end
      default: ;
    endcase
    r.row_total     = row_sum[c.from_state];
    r.nonzero_count = distinct;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STATES; i++) begin
        for (int j = 0; j < STATES; j++) begin
          tally[i][j]    = '0;
          col_list[i][j] = '0;
          run_sum[i][j]  = '0;
        end
        list_len[i] = '0;
        cum_len[i]  = '0;
        row_sum[i]  = '0;
      end
      distinct = '0;
      expected_q.delete();
      cmd_q.delete();
    end else begin
      // results first: a new command may be taken in the cycle of done
      if (done) begin
        n_res++;
        if (expected_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: result word with nothing expected: next %0d total %0d nz %0d",
                     $realtime, result.next_state, result.row_total, result.nonzero_count);
        end else begin
          want     = expected_q.pop_front();
          cmd_seen = cmd_q.pop_front();
          if (result.next_state !== want.next_state || result.row_total !== want.row_total ||
              result.nonzero_count !== want.nonzero_count) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("%0t: mismatch for func %0d row %0d col %0d w %h u %h:",
                       $realtime, cmd_seen.func, cmd_seen.from_state, cmd_seen.to_state,
                       cmd_seen.weight, cmd_seen.uniform);
              $display("  next %0d/%0d total %0d/%0d nz %0d/%0d (expected/actual)",
                       want.next_state, result.next_state, want.row_total,
                       result.row_total, want.nonzero_count, result.nonzero_count);
            end
          end
        end
      end
      if (start && !busy) begin
        predict_word(cmd, want);
        expected_q.insert(expected_q.size(), want);
        cmd_q.insert(cmd_q.size(), cmd);
      end
    end
    fail_count   <= n_fail;
    pending      <= expected_q.size();
    result_count <= n_res;
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the Markov transition sampler. A short directed
// run covers empty rows, zero weights, saturation, stale sums and the spare
// function code; then bursts of adds, a cumulate and a run of samples under
// three idling patterns. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module testbench;
  import mts_pkg::*;

  // Spare function code: the block must treat it like an add that changes
  // nothing.
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // Cycles with no word taken on either channel before the run is abandoned.
  // The slowest correct gaps are the clearing pass after reset and a cumulate
  // over a full table; allow several times the longer of the two.
  localparam int WATCHDOG_LIMIT = 40000;

  // Random words per idling phase; with the directed part this gives at least 1448.
  localparam int PHASE_WORDS = 475;

  logic     clk   = 1'b0;
  logic     rst   = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  mts_in_t  cmd   = '0;
  logic     done;
  mts_out_t result;

  int fail_count;
  int pending;
  int result_count;

  int idle_pct    = 27;
  int n_words     = 0;
  int n_add       = 0;
  int n_cum       = 0;
  int n_smp       = 0;
  int n_spare     = 0;
  int quiet_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  markov_transition_sampler_top uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  mts_checker chk (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .done         (done),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count)
  );

  // Abandon the run when neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
      if (quiet_count >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d quiet cycles, %0d words still due",
                 quiet_count, pending);
        $display("** markov_transition_sampler_top: FAILED **");
        $finish;
      end
    end
  end

  function automatic mts_in_t word_of(input logic [1:0] f, input logic [5:0] fr,
                                      input logic [5:0] to, input logic [31:0] w,
                                      input logic [31:0] u);
    mts_in_t c;
    c.func       = f;
    c.from_state = fr;
    c.to_state   = to;
    c.weight     = w;
    c.uniform    = u;
    return c;
  endfunction

  // Favour a few hot rows so that lists grow long; row 63 is picked most
  // often of all.
  function automatic logic [5:0] pick_row();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 6'd63;
    if (r < 45) return 6'd0;
    if (r < 55) return 6'd1;
    if (r < 62) return 6'd32;
    return 6'($urandom_range(63));
  endfunction

  // Mostly small weights; now and then full range, the top value (to drive
  // counts into saturation) or zero (ignored by the block).
  function automatic logic [31:0] pick_weight();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 32'($urandom_range(1, 1000));
    if (r < 75) return $urandom;
    if (r < 82) return 32'hFFFF_FFFF;
    if (r < 90) return 32'hFFFF_FFFF - 32'($urandom_range(15));
    if (r < 95) return 32'd0;
    return 32'($urandom_range(1, 3));
  endfunction

  function automatic logic [31:0] pick_uniform();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 32'd0;
    if (r < 20) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Offer one word, idling first at the current rate, and hold it until the
  // block takes it. Returns in the step of the accepting edge.
  task automatic issue(input mts_in_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_words++;
    case (c.func)
      FUNC_ADD: n_add++;
      FUNC_CUM: n_cum++;
      FUNC_SMP: n_smp++;
      default:  n_spare++;
    endcase
  endtask

  // Rounds of a burst of adds (now and then a spare code), a cumulate, then a run of
  // samples with a few late adds mixed in so that sampling meets stale sums.
  task automatic run_phase(input int target);
    int stop_at;
    int n;
    stop_at = n_words + target;
    while (n_words < stop_at) begin
      n = $urandom_range(3, 30);
      repeat (n) begin
        if ($urandom_range(99) < 5)
          issue(word_of(FUNC_SPARE, 6'($urandom_range(63)), 6'($urandom_range(63)),
                        $urandom, $urandom));
        else
          issue(word_of(FUNC_ADD, pick_row(), 6'($urandom_range(63)), pick_weight(),
                        $urandom));
      end
      issue(word_of(FUNC_CUM, 6'($urandom_range(63)), 6'($urandom_range(63)), $urandom,
                    $urandom));
      n = $urandom_range(3, 25);
      repeat (n) begin
        if ($urandom_range(99) < 15)
          issue(word_of(FUNC_ADD, pick_row(), 6'($urandom_range(63)), pick_weight(),
                        $urandom));
        else
          issue(word_of(FUNC_SMP, pick_row(), 6'($urandom_range(63)), $urandom,
                        pick_uniform()));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part, under the first idling pattern.
    idle_pct = 27;
    // empty table: sample and cumulate with nothing stored
    issue(word_of(FUNC_SMP, 6'd0, 6'd0, 32'd0, 32'd0));
    issue(word_of(FUNC_CUM, 6'd63, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // zero weight: no entry, no count
    issue(word_of(FUNC_ADD, 6'd5, 6'd9, 32'd0, 32'hFFFF_FFFF));
    // row 0: smallest weight, then drive two cells into saturation
    issue(word_of(FUNC_ADD, 6'd0, 6'd0, 32'd1, 32'd0));
    issue(word_of(FUNC_ADD, 6'd0, 6'd63, 32'hFFFF_FFFF, 32'd0));
    issue(word_of(FUNC_ADD, 6'd0, 6'd63, 32'hFFFF_FFFF, 32'd0));
    issue(word_of(FUNC_ADD, 6'd0, 6'd0, 32'hFFFF_FFFF, 32'd0));
    // row 63: three entries in a known list order
    issue(word_of(FUNC_ADD, 6'd63, 6'd63, 32'd1, 32'd0));
    issue(word_of(FUNC_ADD, 6'd63, 6'd0, 32'd2, 32'd0));
    issue(word_of(FUNC_ADD, 6'd63, 6'd31, 32'h8000_0000, 32'd0));
    // before any cumulate with entries the row total is still zero
    issue(word_of(FUNC_SMP, 6'd0, 6'd0, 32'd0, 32'h8000_0000));
    issue(word_of(FUNC_CUM, 6'd0, 6'd0, 32'd0, 32'd0));
    // thresholds at both ends of the uniform range
    issue(word_of(FUNC_SMP, 6'd0, 6'd0, 32'd0, 32'd0));
    issue(word_of(FUNC_SMP, 6'd0, 6'd0, 32'd0, 32'hFFFF_FFFF));
    issue(word_of(FUNC_SMP, 6'd63, 6'd0, 32'd0, 32'd0));
    issue(word_of(FUNC_SMP, 6'd63, 6'd0, 32'd0, 32'h7FFF_FFFF));
    issue(word_of(FUNC_SMP, 6'd63, 6'd0, 32'd0, 32'hFFFF_FFFF));
    // empty row after a cumulate
    issue(word_of(FUNC_SMP, 6'd1, 6'd0, 32'd0, $urandom));
    // a new entry after the cumulate stays invisible to sampling
    issue(word_of(FUNC_ADD, 6'd63, 6'd5, 32'd7, 32'd0));
    issue(word_of(FUNC_SMP, 6'd63, 6'd0, 32'd0, 32'hFFFF_FFFF));
    // spare code with every field busy
    issue(word_of(FUNC_SPARE, 6'd63, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    issue(word_of(FUNC_CUM, 6'd63, 6'd0, 32'd0, 32'd0));
    issue(word_of(FUNC_SMP, 6'd63, 6'd0, 32'd0, 32'hFFFF_FFFF));

    // Random part: sender idles now and then, then often, then never.
    run_phase(PHASE_WORDS);
    idle_pct = 76;
    run_phase(PHASE_WORDS);
    idle_pct = 0;
    run_phase(PHASE_WORDS);

    // Drop start, let the last word register, then drain the results.
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Run covered %0d command words: %0d adds, %0d cumulates, %0d samples, %0d spare",
             n_words, n_add, n_cum, n_smp, n_spare);
    $display("%0d result words checked, %0d mismatches", result_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("** markov_transition_sampler_top: PASSED **");
    end else begin
      $display("** markov_transition_sampler_top: FAILED **");
    end
    $finish;
  end

endmodule
